/* src/rce_pkg.sv */
`timescale 1ns / 1ps

package rce_pkg;

   // Field widths of the request and response transfers
   localparam int CMD_W      = 2;
   localparam int ROW_W      = 6;
   localparam int DIST_IN_W  = 24;
   localparam int COST_W     = 32;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_CUSTOMERS = 64;
   localparam int DEF_DIST_BITS     = 24;

   // Request commands; code 3 is unused
   typedef enum logic [CMD_W-1:0] {
      CMD_PAIR  = 2'd0,
      CMD_DEPOT = 2'd1,
      CMD_VISIT = 2'd2
   } cmd_type;

   // Per-visit control carried from the table read into the accumulate stage
   typedef struct packed {
      logic in_route;   // add the pair distance from the previous customer
      logic first_ok;   // first term addresses a table entry that exists
      logic close;      // route closes here: add the depot distance again
      logic depot_ok;   // customer index lies within the depot table
      logic emit;       // last visit of the solution: send the total
   } visit_ctl_type;

endpackage

/* src/rce_ram.sv */
`timescale 1ns / 1ps

module rce_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read; hold the data while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/rce_accum.sv */
`timescale 1ns / 1ps

module rce_accum #(
   parameter int DIST_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  rce_pkg::visit_ctl_type        ctl,
   input  logic [DIST_BITS-1:0]          pair_data,
   input  logic [DIST_BITS-1:0]          depot_data,
   output logic                          hold,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rce_pkg::COST_W-1:0]    rsp_total_cost,
   output logic                          rsp_cost_saturated
);

   import rce_pkg::*;

   localparam int SUM_W = COST_W + 2;

   logic                  s1_valid_ff, s1_valid_in;
   visit_ctl_type         s1_ctl_ff;
   logic [COST_W-1:0]     acc_ff, acc_in;
   logic                  sat_ff, sat_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0]     rsp_total_ff;
   logic                  rsp_sat_ff;

   logic                  advance;
   logic [DIST_BITS-1:0]  first_term;
   logic [DIST_BITS-1:0]  close_term;
   logic [SUM_W-1:0]      sum;
   logic                  overflow;
   logic [COST_W-1:0]     new_total;
   logic                  new_sat;

   // Stall the stage only when it must emit and the response register is blocked
   assign advance = s1_valid_ff && !(s1_ctl_ff.emit && rsp_valid_ff && rsp_stall);
   assign hold    = s1_valid_ff && !advance;

   // Pick the distances this visit adds
   always_comb begin
      first_term = '0;
      close_term = '0;
      if (s1_ctl_ff.first_ok) begin
         first_term = s1_ctl_ff.in_route ? pair_data : depot_data;
      end
      if (s1_ctl_ff.close && s1_ctl_ff.depot_ok) begin
         close_term = depot_data;
      end
   end

   // Add both terms at once; clamping once equals clamping after each add
   assign sum       = SUM_W'(acc_ff) + SUM_W'(first_term) + SUM_W'(close_term);
   assign overflow  = sum > SUM_W'({COST_W{1'b1}});
   assign new_total = overflow ? {COST_W{1'b1}} : sum[COST_W-1:0];
   assign new_sat   = sat_ff | overflow;

   // Next state of the stage and the accumulator
   always_comb begin
      s1_valid_in = s1_valid_ff;
      acc_in      = acc_ff;
      sat_in      = sat_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
         if (s1_ctl_ff.emit) begin
            acc_in = '0;
            sat_in = 1'b0;
         end else begin
            acc_in = new_total;
            sat_in = new_sat;
         end
      end
      if (load) begin
         s1_valid_in = 1'b1;
      end
   end

   // Set the response on emit, drop it after its transfer
   always_comb begin
      priority if (advance && s1_ctl_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture visit control and the response payload
   always_ff @(posedge clock) begin
      if (load) begin
         s1_ctl_ff <= ctl;
      end
      if (advance && s1_ctl_ff.emit) begin
         rsp_total_ff <= new_total;
         rsp_sat_ff   <= new_sat;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_total_cost     = rsp_total_ff;
   assign rsp_cost_saturated = rsp_sat_ff;

endmodule

/* src/route_cost_evaluator.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  cmd, row_index, col_index,
//                                             distance_value, route_end, solution_end
// rsp_      out        rsp_valid / rsp_stall  total_cost, cost_saturated
//
// One request is taken per cycle while req_stall is low. Table writes land in memory
// at their transfer edge. A visit reads both distance memories at its transfer edge
// into registered outputs; the add stage sums them and registers the total on rsp_.
// Reset clears route state and the accumulator; the tables hold garbage until written.
// req_stall rises only while a finished total waits on a stalled rsp_ channel.

module route_cost_evaluator #(
   parameter int MAX_CUSTOMERS = rce_pkg::DEF_MAX_CUSTOMERS,
   parameter int DIST_BITS     = rce_pkg::DEF_DIST_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rce_pkg::CMD_W-1:0]      req_cmd,
   input  logic [rce_pkg::ROW_W-1:0]      req_row_index,
   input  logic [rce_pkg::ROW_W-1:0]      req_col_index,
   input  logic [rce_pkg::DIST_IN_W-1:0]  req_distance_value,
   input  logic                           req_route_end,
   input  logic                           req_solution_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rce_pkg::COST_W-1:0]     rsp_total_cost,
   output logic                           rsp_cost_saturated
);

   import rce_pkg::*;

   localparam int CUST_W     = $clog2(MAX_CUSTOMERS);
   localparam int IDX_W      = (CUST_W > ROW_W) ? CUST_W : ROW_W;
   localparam int CMP_W      = IDX_W + 1;
   localparam int PAIR_DEPTH = MAX_CUSTOMERS * MAX_CUSTOMERS;
   localparam int PAIR_AW    = $clog2(PAIR_DEPTH);

   logic                  accept;
   cmd_type               cmd;
   logic                  is_pair_wr, is_depot_wr, is_visit;
   logic                  row_ok, col_ok, prev_ok;
   logic [PAIR_AW-1:0]    pair_wr_addr, pair_rd_addr;
   logic [CUST_W-1:0]     depot_addr;
   logic [DIST_BITS-1:0]  dist_wr;
   logic [DIST_BITS-1:0]  pair_data, depot_data;
   logic                  hold;
   logic                  closes;
   visit_ctl_type         ctl;

   logic [ROW_W-1:0]      prev_ff, prev_in;
   logic                  inside_ff, inside_in;

   assign accept = req_valid && !req_stall;
   assign cmd    = cmd_type'(req_cmd);

   // Decode the command
   always_comb begin
      is_pair_wr  = 1'b0;
      is_depot_wr = 1'b0;
      is_visit    = 1'b0;
      unique case (cmd)
         CMD_PAIR:  is_pair_wr  = 1'b1;
         CMD_DEPOT: is_depot_wr = 1'b1;
         CMD_VISIT: is_visit    = 1'b1;
         default: ;
      endcase
   end

   // Range checks and table addresses
   assign row_ok  = CMP_W'(req_row_index) < CMP_W'(MAX_CUSTOMERS);
   assign col_ok  = CMP_W'(req_col_index) < CMP_W'(MAX_CUSTOMERS);
   assign prev_ok = CMP_W'(prev_ff) < CMP_W'(MAX_CUSTOMERS);

   assign pair_wr_addr = PAIR_AW'(PAIR_AW'(req_row_index) * PAIR_AW'(MAX_CUSTOMERS)
                                 + PAIR_AW'(req_col_index));
   assign pair_rd_addr = PAIR_AW'(PAIR_AW'(prev_ff) * PAIR_AW'(MAX_CUSTOMERS)
                                 + PAIR_AW'(req_row_index));
   assign depot_addr   = CUST_W'(req_row_index);
   assign dist_wr      = DIST_BITS'(req_distance_value);

   // Track the route position at each visit transfer
   assign closes = req_route_end || req_solution_end;

   always_comb begin
      prev_in   = prev_ff;
      inside_in = inside_ff;
      if (accept && is_visit) begin
         prev_in   = req_row_index;
         inside_in = !closes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         inside_ff <= 1'b0;
      end else begin
         prev_ff   <= prev_in;
         inside_ff <= inside_in;
      end
   end

   // Control that travels with the visit into the add stage
   always_comb begin
      ctl.in_route = inside_ff;
      ctl.first_ok = inside_ff ? (row_ok && prev_ok) : row_ok;
      ctl.close    = closes;
      ctl.depot_ok = row_ok;
      ctl.emit     = req_solution_end;
   end

   rce_ram #(
      .WIDTH (DIST_BITS),
      .DEPTH (PAIR_DEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (accept && is_pair_wr && row_ok && col_ok),
      .wr_addr (pair_wr_addr),
      .wr_data (dist_wr),
      .rd_en   (accept && is_visit),
      .rd_addr (pair_rd_addr),
      .rd_data (pair_data)
   );

   rce_ram #(
      .WIDTH (DIST_BITS),
      .DEPTH (MAX_CUSTOMERS)
   ) u_depot_ram (
      .clock   (clock),
      .wr_en   (accept && is_depot_wr && row_ok),
      .wr_addr (depot_addr),
      .wr_data (dist_wr),
      .rd_en   (accept && is_visit),
      .rd_addr (depot_addr),
      .rd_data (depot_data)
   );

   rce_accum #(
      .DIST_BITS (DIST_BITS)
   ) u_accum (
      .clock              (clock),
      .reset              (reset),
      .load               (accept && is_visit),
      .ctl                (ctl),
      .pair_data          (pair_data),
      .depot_data         (depot_data),
      .hold               (hold),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_total_cost     (rsp_total_cost),
      .rsp_cost_saturated (rsp_cost_saturated)
   );

   assign req_stall = hold;

`ifndef SYNTH
   // Requests back up only behind a blocked response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a blocked response");

   // A visit that closes its route leaves the block outside any route
   a_route_close: assert property (@(posedge clock) disable iff (reset)
      (accept && is_visit && closes) |=> !inside_ff)
      else $error("route still open after closing visit");

   // A saturated total is reported at its maximum
   a_sat_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cost_saturated) |-> (rsp_total_cost == {COST_W{1'b1}}))
      else $error("saturated total below maximum");
`endif

endmodule

/* tb/tb_route_cost_evaluator.sv */
`timescale 1ns / 1ps

module tb_route_cost_evaluator;
   import rce_pkg::*;

   localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
   localparam logic [DIST_IN_W-1:0] DIST_MAX   = 24'hFF_FFFF;
   localparam logic [DIST_IN_W-1:0] DIST_BIG   = 24'hF0_0000;
   localparam int                   STIM_ROWS  = 18;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [ROW_W-1:0]     row;
      logic [ROW_W-1:0]     col;
      logic [DIST_IN_W-1:0] distance;
      logic                 route_end;
      logic                 solution_end;
   } route_req_type;

   typedef struct packed {
      logic [COST_W-1:0] total;
      logic              saturated;
   } cost_result_type;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [ROW_W-1:0]     row;
      logic [ROW_W-1:0]     col;
      logic [DIST_IN_W-1:0] distance;
      logic                 route_end;
      logic                 solution_end;
      logic                 typed;
      logic [COST_W-1:0]    total;
      logic                 saturated;
   } stim_row_type;

   // Directed rows; a typed total is checked as given, the rest against the predictor
   localparam stim_row_type STIM_TABLE [0:STIM_ROWS-1] = '{
      // unused command with every field at its maximum: ignored
      '{CMD_UNUSED, 6'd63, 6'd63, DIST_MAX, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
      '{CMD_DEPOT,  6'd0,  6'd0,  24'd0,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{CMD_DEPOT,  6'd63, 6'd63, DIST_MAX, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
      // zero depot distance counted twice
      '{CMD_VISIT,  6'd0,  6'd0,  24'd0,    1'b1, 1'b1, 1'b1, 32'd0, 1'b0},
      // maximum depot distance counted twice
      '{CMD_VISIT,  6'd63, 6'd0,  24'd0,    1'b1, 1'b1, 1'b1, 32'h01FF_FFFE, 1'b0},
      '{CMD_PAIR,   6'd0,  6'd63, DIST_MAX, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{CMD_PAIR,   6'd63, 6'd0,  24'h100,  1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
      '{CMD_VISIT,  6'd0,  6'd0,  24'd0,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{CMD_VISIT,  6'd63, 6'd0,  24'd0,    1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
      '{CMD_VISIT,  6'd63, 6'd0,  24'd0,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      // unused command in the middle of a route
      '{CMD_UNUSED, 6'd0,  6'd0,  24'd0,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      // solution end without route end closes the route
      '{CMD_VISIT,  6'd0,  6'd63, DIST_MAX, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0},
      '{CMD_DEPOT,  6'd63, 6'd0,  24'd1,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      // overwritten depot entry, single visit closed by solution end
      '{CMD_VISIT,  6'd63, 6'd0,  24'd0,    1'b0, 1'b1, 1'b1, 32'd2, 1'b0},
      '{CMD_PAIR,   6'd63, 6'd63, 24'hFF,   1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{CMD_VISIT,  6'd63, 6'd0,  24'd0,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{CMD_VISIT,  6'd63, 6'd0,  24'd0,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{CMD_VISIT,  6'd63, 6'd0,  24'd0,    1'b1, 1'b1, 1'b0, 32'd0, 1'b0}
   };

   logic                 clock              = 1'b0;
   logic                 reset              = 1'b1;
   logic                 req_valid          = 1'b0;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_cmd            = '0;
   logic [ROW_W-1:0]     req_row_index      = '0;
   logic [ROW_W-1:0]     req_col_index      = '0;
   logic [DIST_IN_W-1:0] req_distance_value = '0;
   logic                 req_route_end      = 1'b0;
   logic                 req_solution_end   = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall          = 1'b0;
   logic [COST_W-1:0]    rsp_total_cost;
   logic                 rsp_cost_saturated;

   // Predictor state
   logic [DIST_IN_W-1:0] pair_dist   [0:4095];
   logic [DIST_IN_W-1:0] depot_dist  [0:63];
   bit                   pair_loaded [0:4095];
   bit                   depot_loaded[0:63];
   logic [ROW_W-1:0]     last_cust    = '0;
   bit                   on_route     = 1'b0;
   logic [COST_W-1:0]    cost_sum     = '0;
   bit                   cost_clamped = 1'b0;

   cost_result_type      total_q[$];
   int                   mismatch_count = 0;
   int                   random_count   = 0;
   bit                   calm           = 1'b0;
   int unsigned          phase_left     = 0;
   int unsigned          stall_left     = 0;

   route_cost_evaluator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_row_index      (req_row_index),
      .req_col_index      (req_col_index),
      .req_distance_value (req_distance_value),
      .req_route_end      (req_route_end),
      .req_solution_end   (req_solution_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_total_cost     (rsp_total_cost),
      .rsp_cost_saturated (rsp_cost_saturated)
   );

   always #5 clock = ~clock;

   // Add one distance, clamping at the top of the accumulator
   function automatic void add_distance(input logic [DIST_IN_W-1:0] d);
      logic [COST_W:0] s;
      s = {1'b0, cost_sum} + (COST_W+1)'(d);
      if (s[COST_W]) begin
         cost_sum     = '1;
         cost_clamped = 1'b1;
      end else begin
         cost_sum = s[COST_W-1:0];
      end
   endfunction

   // Advance the route state by one transfer; returns 1 when a total is due
   function automatic bit advance_cost(input route_req_type it,
                                       output cost_result_type res);
      res = '0;
      case (it.cmd)
         CMD_PAIR: begin
            pair_dist[{it.row, it.col}]   = it.distance;
            pair_loaded[{it.row, it.col}] = 1'b1;
            return 1'b0;
         end
         CMD_DEPOT: begin
            depot_dist[it.row]   = it.distance;
            depot_loaded[it.row] = 1'b1;
            return 1'b0;
         end
         CMD_VISIT: begin
            if (on_route) add_distance(pair_dist[{last_cust, it.row}]);
            else add_distance(depot_dist[it.row]);
            if (it.route_end || it.solution_end) add_distance(depot_dist[it.row]);
            on_route  = !(it.route_end || it.solution_end);
            last_cust = it.row;
            if (!it.solution_end) return 1'b0;
            res.total     = cost_sum;
            res.saturated = cost_clamped;
            cost_sum      = '0;
            cost_clamped  = 1'b0;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Idle length: mostly none or short, a few long, none in a calm phase
   function automatic int unsigned idle_len();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DIST_IN_W-1:0] pick_dist(input bit big);
      int unsigned r;
      if (big) return DIST_IN_W'($urandom_range(DIST_BIG, DIST_MAX));
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return DIST_MAX;
      return DIST_IN_W'($urandom);
   endfunction

   function automatic route_req_type random_req();
      route_req_type it;
      it.cmd          = CMD_W'($urandom);
      it.row          = ROW_W'($urandom);
      it.col          = ROW_W'($urandom);
      it.distance     = DIST_IN_W'($urandom);
      it.route_end    = 1'($urandom);
      it.solution_end = 1'($urandom);
      return it;
   endfunction

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   // Drive one transfer, hold it through stalls, then predict its total
   task automatic send_item(input route_req_type it, input bit typed,
                            input cost_result_type want);
      int unsigned     gap;
      cost_result_type got;
      gap = idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_cmd            <= it.cmd;
      req_row_index      <= it.row;
      req_col_index      <= it.col;
      req_distance_value <= it.distance;
      req_route_end      <= it.route_end;
      req_solution_end   <= it.solution_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (advance_cost(it, got)) total_q.push_back(typed ? want : got);
   endtask

   task automatic write_table(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                              input logic [ROW_W-1:0] col, input logic [DIST_IN_W-1:0] d);
      route_req_type it;
      it          = random_req();
      it.cmd      = cmd;
      it.row      = row;
      it.col      = col;
      it.distance = d;
      send_item(it, 1'b0, '0);
      random_count++;
   endtask

   // Visit a customer, loading any distance it needs first
   task automatic visit(input logic [ROW_W-1:0] cust, input bit rend, input bit send,
                        input bit big);
      route_req_type it;
      if (!depot_loaded[cust])
         write_table(CMD_DEPOT, cust, ROW_W'($urandom), pick_dist(big));
      if (on_route && !pair_loaded[{last_cust, cust}])
         write_table(CMD_PAIR, last_cust, cust, pick_dist(big));
      // occasional noise: unused command or a stray table write
      if (!big && $urandom_range(0, 99) < 8) begin
         it = random_req();
         if ($urandom_range(0, 1) == 0) begin
            it.cmd = CMD_UNUSED;
            send_item(it, 1'b0, '0);
         end else begin
            write_table($urandom_range(0, 1) ? CMD_PAIR : CMD_DEPOT, it.row, it.col,
                        pick_dist(1'b0));
         end
      end
      it              = random_req();
      it.cmd          = CMD_VISIT;
      it.row          = cust;
      it.route_end    = rend;
      it.solution_end = send;
      send_item(it, 1'b0, '0);
      random_count++;
   endtask

   // Short routes over a small customer pool, sometimes ended by solution end alone
   task automatic run_solution();
      int unsigned      n_routes, len, r, v;
      bit               last;
      logic [ROW_W-1:0] cust;
      n_routes = $urandom_range(1, 4);
      for (r = 0; r < n_routes; r++) begin
         len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 12);
         for (v = 0; v < len; v++) begin
            last = (r == n_routes - 1) && (v == len - 1);
            cust = ($urandom_range(0, 9) < 7) ? ROW_W'($urandom_range(0, 7))
                                               : ROW_W'($urandom_range(0, 63));
            visit(cust, last ? 1'($urandom_range(0, 1)) : (v == len - 1), last, 1'b0);
         end
      end
   endtask

   // Long routes over large distances to drive the sum into saturation
   task automatic run_heavy();
      logic [ROW_W-1:0] base;
      int unsigned      i, j, r, v, len;
      base = ROW_W'($urandom_range(0, 60));
      for (i = 0; i < 4; i++) begin
         write_table(CMD_DEPOT, base + ROW_W'(i), ROW_W'($urandom), pick_dist(1'b1));
         for (j = 0; j < 4; j++)
            write_table(CMD_PAIR, base + ROW_W'(i), base + ROW_W'(j), pick_dist(1'b1));
      end
      for (r = 0; r < 2; r++) begin
         len = $urandom_range(140, 150);
         for (v = 0; v < len; v++)
            visit(base + ROW_W'($urandom_range(0, 3)), v == len - 1,
                  (r == 1) && (v == len - 1), 1'b1);
      end
   endtask

   // Alternate busy phases with calm stretches that have no idling
   always @(posedge clock) begin
      if (phase_left == 0) begin
         calm       <= ($urandom_range(0, 3) == 0);
         phase_left <= $urandom_range(50, 400);
      end else begin
         phase_left <= phase_left - 1;
      end
   end

   // Stall the result channel in random bursts
   always @(posedge clock) begin : stall_results
      int unsigned n;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         n = idle_len();
         rsp_stall  <= (n != 0);
         stall_left <= (n != 0) ? n - 1 : 0;
      end
   end

   // Compare each result transfer with the oldest predicted total
   always @(posedge clock) begin : check_totals
      cost_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (total_q.size() == 0) begin
            flag_error($sformatf("unexpected total: cost %h saturated %b",
                                 rsp_total_cost, rsp_cost_saturated));
         end else begin
            want = total_q.pop_front();
            if (rsp_total_cost !== want.total)
               flag_error($sformatf("total_cost mismatch: expected %h actual %h",
                                    want.total, rsp_total_cost));
            if (rsp_cost_saturated !== want.saturated)
               flag_error($sformatf("cost_saturated mismatch: expected %b actual %b",
                                    want.saturated, rsp_cost_saturated));
         end
      end
   end

   initial begin
      #(20_000_000);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      route_req_type   it;
      cost_result_type want;
      int              k, sol;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed rows
      for (k = 0; k < STIM_ROWS; k++) begin
         it.cmd          = STIM_TABLE[k].cmd;
         it.row          = STIM_TABLE[k].row;
         it.col          = STIM_TABLE[k].col;
         it.distance     = STIM_TABLE[k].distance;
         it.route_end    = STIM_TABLE[k].route_end;
         it.solution_end = STIM_TABLE[k].solution_end;
         want.total      = STIM_TABLE[k].total;
         want.saturated  = STIM_TABLE[k].saturated;
         send_item(it, STIM_TABLE[k].typed, want);
      end

      // Random solutions, a heavy one now and then
      sol = 0;
      while (random_count < 1000) begin
         if (sol % 15 == 7) run_heavy();
         else run_solution();
         sol++;
      end
      req_valid <= 1'b0;

      // Drain outstanding totals, then let the pipeline settle
      while (total_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
